>>> hw/rtl/sukt_pkg.sv
// sukt_pkg: shared types and codes for the sorted unique key table
// depends on nothing; imported by the interfaces, the cell row and the top level
package sukt_pkg;

    localparam int KEY_W    = 32;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;

    typedef logic signed [KEY_W-1:0] t_key;

    // item kinds
    typedef enum logic [KIND_W-1:0] {
        K_INSERT    = 2'd0,
        K_FIND      = 2'd1,
        K_LIST_ASC  = 2'd2,
        K_LIST_DESC = 2'd3
    } t_kind;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        S_PRESENT  = 3'd0,
        S_INSERTED = 3'd1,
        S_ABSENT   = 3'd2,
        S_FULL     = 3'd3,
        S_LISTED   = 3'd4,
        S_EMPTY    = 3'd5
    } t_status;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_EXEC,
        ST_LIST
    } t_state;

    // compare flags a cell holds and shows to its neighbors
    typedef struct packed {
        logic lt;   // stored key below the probe key
        logic eq;   // stored key equals the probe key
        logic hit;  // stored key inside the list range
    } t_cell_st;

    // controls broadcast from the sequencer to every cell
    typedef struct packed {
        logic cmp_en;     // capture compare flags
        logic ins_en;     // open a slot and write the new key
        logic tok_load;   // place the read token at the run start
        logic tok_shift;  // pass the read token to the next cell
        logic desc;       // token walks downward
    } t_cell_ctl;

endpackage

>>> hw/rtl/sukt_in_if.sv
// sukt_in_if: input item channel, valid/ready handshake with the item fields
// depends on sukt_pkg
interface sukt_in_if import sukt_pkg::*;;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    t_key              key;
    t_key              range_low;
    t_key              range_high;

    modport source (output valid, kind, key, range_low, range_high, input ready);
    modport sink   (input valid, kind, key, range_low, range_high, output ready);
endinterface

>>> hw/rtl/sukt_out_if.sv
// sukt_out_if: result channel, valid/ready handshake with the result fields
// depends on sukt_pkg; POS_W must match the table's position width
interface sukt_out_if import sukt_pkg::*; #(
    parameter int POS_W = 7
);
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    t_key                key_out;
    logic                last;

    modport source (output valid, status, position, key_out, last, input ready);
    modport sink   (input valid, status, position, key_out, last, output ready);
endinterface

>>> hw/rtl/sorted_unique_key_table_top.sv
// sorted_unique_key_table_top: ascending table of distinct signed keys held in a row of cells
// insert/find: a compare state captures flags across all cells, then an exec state decides,
//   shift-inserts and registers the result; a new item is taken as the last one finishes
// list: after the compare and exec states, one result beat per cycle while the output is not
//   stalled, as the read token walks; a list with no match gives its range empty beat from exec
// reset: fill count and control state cleared; cell keys are left as they are, no clearing pass
module sorted_unique_key_table_top import sukt_pkg::*; #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sukt_in_if.sink           i_item,
    sukt_out_if.source        o_result
);

    localparam int POS_W = $clog2(TABLE_DEPTH + 1);

    t_state            r_state, n_state;
    logic [POS_W-1:0]  r_count, n_count;
    t_kind             r_kind;
    t_key              r_key;
    t_key              r_range_low;
    t_key              r_range_high;

    logic              r_o_valid, n_o_valid;
    t_status           r_o_status, n_o_status;
    logic [POS_W-1:0]  r_o_pos, n_o_pos;
    t_key              r_o_key, n_o_key;
    logic              r_o_last, n_o_last;

    t_cell_ctl         w_ctl;
    t_key              w_key [TABLE_DEPTH];
    t_cell_st          w_st  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_tok, w_bnd, w_tok_last, w_eq, w_hit;
    logic [POS_W-1:0]  w_eq_pos, w_bnd_pos, w_tok_pos;
    t_key              w_sel_key;
    logic              w_free, w_finish, w_accept, w_in_ready;

    // cell row
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        t_key     w_lkey;
        t_cell_st w_lst, w_rst;
        logic     w_ltok, w_rtok;

        if (g == 0) begin : g_lo
            assign w_lkey = r_key;
            assign w_lst  = '{lt: 1'b1, eq: 1'b0, hit: 1'b0};
            assign w_ltok = 1'b0;
        end else begin : g_mid_lo
            assign w_lkey = w_key[g-1];
            assign w_lst  = w_st[g-1];
            assign w_ltok = w_tok[g-1];
        end
        if (g == TABLE_DEPTH - 1) begin : g_hi
            assign w_rst  = '{lt: 1'b0, eq: 1'b0, hit: 1'b0};
            assign w_rtok = 1'b0;
        end else begin : g_mid_hi
            assign w_rst  = w_st[g+1];
            assign w_rtok = w_tok[g+1];
        end

        sukt_cell #(.IDX(g), .POS_W(POS_W)) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_count      (r_count),
            .i_key        (r_key),
            .i_range_low  (r_range_low),
            .i_range_high (r_range_high),
            .i_left_key   (w_lkey),
            .i_left_st    (w_lst),
            .i_right_st   (w_rst),
            .i_left_tok   (w_ltok),
            .i_right_tok  (w_rtok),
            .o_key        (w_key[g]),
            .o_st         (w_st[g]),
            .o_tok        (w_tok[g]),
            .o_bnd        (w_bnd[g]),
            .o_tok_last   (w_tok_last[g])
        );

        assign w_eq[g]  = w_st[g].eq;
        assign w_hit[g] = w_st[g].hit;
    end

    // position encoders
    sukt_enc #(.N(TABLE_DEPTH), .IDX_W(POS_W)) u_enc_eq (
        .i_onehot (w_eq),
        .o_index  (w_eq_pos)
    );
    sukt_enc #(.N(TABLE_DEPTH), .IDX_W(POS_W)) u_enc_bnd (
        .i_onehot (w_bnd),
        .o_index  (w_bnd_pos)
    );
    sukt_enc #(.N(TABLE_DEPTH), .IDX_W(POS_W)) u_enc_tok (
        .i_onehot (w_tok),
        .o_index  (w_tok_pos)
    );

    // key under the read token
    always_comb begin
        w_sel_key = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_sel_key = w_sel_key | (w_key[i] & {KEY_W{w_tok[i]}});
        end
    end

    assign w_free   = !r_o_valid || o_result.ready;
    assign w_accept = i_item.valid && w_in_ready;

    // sequencer: next state, cell controls and result beat
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_o_valid  = r_o_valid && !o_result.ready;
        n_o_status = r_o_status;
        n_o_pos    = r_o_pos;
        n_o_key    = r_o_key;
        n_o_last   = r_o_last;
        w_ctl      = '0;
        w_ctl.desc = (r_kind == K_LIST_DESC);
        w_finish   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
            end
            ST_CMP: begin
                w_ctl.cmp_en = 1'b1;
                n_state      = ST_EXEC;
            end
            ST_EXEC: begin
                if (w_free) begin
                    if (r_kind == K_INSERT || r_kind == K_FIND) begin
                        n_o_valid = 1'b1;
                        n_o_key   = r_key;
                        n_o_last  = 1'b1;
                        n_o_pos   = '0;
                        w_finish  = 1'b1;
                        if (|w_eq) begin
                            n_o_status = S_PRESENT;
                            n_o_pos    = w_eq_pos;
                        end else if (r_kind == K_FIND) begin
                            n_o_status = S_ABSENT;
                        end else if (r_count >= POS_W'(TABLE_DEPTH)) begin
                            n_o_status = S_FULL;
                        end else begin
                            n_o_status   = S_INSERTED;
                            n_o_pos      = w_bnd_pos;
                            w_ctl.ins_en = 1'b1;
                            n_count      = r_count + POS_W'(1);
                        end
                    end else if (!(|w_hit)) begin
                        n_o_valid  = 1'b1;
                        n_o_status = S_EMPTY;
                        n_o_pos    = '0;
                        n_o_key    = '0;
                        n_o_last   = 1'b1;
                        w_finish   = 1'b1;
                    end else begin
                        w_ctl.tok_load = 1'b1;
                        n_state        = ST_LIST;
                    end
                end
            end
            ST_LIST: begin
                if (w_free) begin
                    n_o_valid       = 1'b1;
                    n_o_status      = S_LISTED;
                    n_o_pos         = w_tok_pos;
                    n_o_key         = w_sel_key;
                    n_o_last        = |w_tok_last;
                    w_ctl.tok_shift = 1'b1;
                    w_finish        = |w_tok_last;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        w_in_ready = (r_state == ST_IDLE) || w_finish;
        if (w_finish) begin
            n_state = ST_IDLE;
        end
        if (i_item.valid && w_in_ready) begin
            n_state = ST_CMP;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind       <= t_kind'(i_item.kind);
            r_key        <= i_item.key;
            r_range_low  <= i_item.range_low;
            r_range_high <= i_item.range_high;
        end
        r_o_status <= n_o_status;
        r_o_pos    <= n_o_pos;
        r_o_key    <= n_o_key;
        r_o_last   <= n_o_last;
    end

    assign i_item.ready      = w_in_ready;
    assign o_result.valid    = r_o_valid;
    assign o_result.status   = r_o_status;
    assign o_result.position = r_o_pos;
    assign o_result.key_out  = r_o_key;
    assign o_result.last     = r_o_last;

    // fill count never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= POS_W'(TABLE_DEPTH))
        else $error("fill count above table depth");

    // an insert only opens a slot when the table has room
    a_ins_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins_en |-> (r_count < POS_W'(TABLE_DEPTH)))
        else $error("insert into a full table");

    // stored keys are distinct, so at most one cell matches
    a_eq_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |-> $onehot0(w_eq))
        else $error("duplicate key in table");

    // exactly one read token while listing
    a_tok_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LIST) |-> $onehot(w_tok))
        else $error("read token lost or duplicated");

endmodule

>>> hw/rtl/sukt_cell.sv
// sukt_cell: one slot of the sorted table, key register, compare flags and read token
// depends on sukt_pkg; instantiated in a row by sorted_unique_key_table_top
module sukt_cell import sukt_pkg::*; #(
    parameter int IDX   = 0,
    parameter int POS_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic [POS_W-1:0] i_count,
    input  t_key             i_key,
    input  t_key             i_range_low,
    input  t_key             i_range_high,
    input  t_key             i_left_key,
    input  t_cell_st         i_left_st,
    input  t_cell_st         i_right_st,
    input  logic             i_left_tok,
    input  logic             i_right_tok,
    output t_key             o_key,
    output t_cell_st         o_st,
    output logic             o_tok,
    output logic             o_bnd,
    output logic             o_tok_last
);

    t_key     r_key;
    t_cell_st r_st;
    t_cell_st n_st;
    logic     r_tok;
    logic     w_occ;

    // slot holds a live key when its index is below the fill count
    assign w_occ = (POS_W'(IDX) < i_count);

    // compare the stored key against the probe and the range
    always_comb begin
        n_st.lt  = w_occ && (r_key < i_key);
        n_st.eq  = w_occ && (r_key == i_key);
        n_st.hit = w_occ && (r_key >= i_range_low) && (r_key <= i_range_high);
    end

    // flags and key; on insert the boundary slot takes the new key, every slot above it its left neighbor
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_st <= n_st;
        end
        if (i_ctl.ins_en && !r_st.lt) begin
            r_key <= i_left_st.lt ? i_key : i_left_key;
        end
    end

    // read token, loaded at the run start and walked one cell per beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else if (i_ctl.tok_load) begin
            r_tok <= i_ctl.desc ? (r_st.hit && !i_right_st.hit)
                                : (r_st.hit && !i_left_st.hit);
        end else if (i_ctl.tok_shift) begin
            r_tok <= i_ctl.desc ? i_right_tok : i_left_tok;
        end
    end

    assign o_key      = r_key;
    assign o_st       = r_st;
    assign o_tok      = r_tok;
    // insert boundary: first slot whose key is not below the probe
    assign o_bnd      = !r_st.lt && i_left_st.lt;
    // token sits at the far end of the run
    assign o_tok_last = r_tok && (i_ctl.desc ? !i_left_st.hit : !i_right_st.hit);

endmodule

>>> hw/rtl/sukt_enc.sv
// sukt_enc: one-hot to index encoder over the cell row
// depends on nothing; used by sorted_unique_key_table_top
module sukt_enc #(
    parameter int N     = 64,
    parameter int IDX_W = 7
) (
    input  logic [N-1:0]     i_onehot,
    output logic [IDX_W-1:0] o_index
);

    // or together the indices of set bits
    always_comb begin
        o_index = '0;
        for (int i = 0; i < N; i++) begin
            if (i_onehot[i]) begin
                o_index = o_index | IDX_W'(i);
            end
        end
    end

endmodule
